### sv/mppt_spo_pkg.sv
// ----------------------------------------------------------------------------
// MPPT sweep and perturb-and-observe package
// Shared types, register indexes and reset constants of the tracker.
// ----------------------------------------------------------------------------
package mppt_spo_pkg;

  localparam int unsigned DutyW  = 15;
  localparam int unsigned StepW  = 10;
  localparam int unsigned VoltW  = 16;
  localparam int unsigned PowerW = 32;

  typedef enum logic [1:0] {
    CFG_DUTY_MIN          = 2'd0,
    CFG_DUTY_MAX          = 2'd1,
    CFG_STEP_SIZE         = 2'd2,
    CFG_MIN_SWEEP_VOLTAGE = 2'd3
  } cfg_idx_e;

  localparam logic [DutyW-1:0] DutyMinReset = '0;
  localparam logic [DutyW-1:0] DutyMaxReset = '1;
  localparam logic [StepW-1:0] StepReset    = StepW'(1);
  localparam logic [VoltW-1:0] MinVoltReset = '0;

  typedef struct packed {
    logic [DutyW-1:0] duty_min;
    logic [DutyW-1:0] duty_max;
    logic [StepW-1:0] step_size;
    logic [VoltW-1:0] min_sweep_voltage;
  } cfg_t;

  typedef struct packed {
    logic [VoltW-1:0] panel_voltage;
    logic [VoltW-1:0] panel_current;
  } in_t;

  typedef struct packed {
    logic [DutyW-1:0]  duty;
    logic              tracking;
    logic [DutyW-1:0]  peak_duty;
    logic [PowerW-1:0] peak_power;
  } out_t;

  typedef struct packed {
    logic [VoltW-1:0]  volts;
    logic [PowerW-1:0] power;
  } smp_t;

endpackage

### sv/mppt_spo_cfg.sv
// ----------------------------------------------------------------------------
// MPPT configuration registers
// Holds the duty limits, the tracking step and the sweep voltage threshold.
// ----------------------------------------------------------------------------
module mppt_spo_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  mppt_spo_pkg::cfg_idx_e         cfg_index_i,
  input  logic [mppt_spo_pkg::VoltW-1:0] cfg_data_i,
  output mppt_spo_pkg::cfg_t             cfg_o
);

  mppt_spo_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mppt_spo_pkg::CFG_DUTY_MIN:
          cfg_d.duty_min = cfg_data_i[mppt_spo_pkg::DutyW-1:0];
        mppt_spo_pkg::CFG_DUTY_MAX:
          cfg_d.duty_max = cfg_data_i[mppt_spo_pkg::DutyW-1:0];
        mppt_spo_pkg::CFG_STEP_SIZE:
          cfg_d.step_size = cfg_data_i[mppt_spo_pkg::StepW-1:0];
        mppt_spo_pkg::CFG_MIN_SWEEP_VOLTAGE:
          cfg_d.min_sweep_voltage = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_min          <= mppt_spo_pkg::DutyMinReset;
      cfg_q.duty_max          <= mppt_spo_pkg::DutyMaxReset;
      cfg_q.step_size         <= mppt_spo_pkg::StepReset;
      cfg_q.min_sweep_voltage <= mppt_spo_pkg::MinVoltReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### sv/mppt_spo_power.sv
// ----------------------------------------------------------------------------
// MPPT sample and power stage
// Registers the incoming sample, then registers the voltage with its power.
// ----------------------------------------------------------------------------
module mppt_spo_power (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mppt_spo_pkg::in_t  in_data_i,
  output logic               smp_valid_o,
  input  logic               smp_ready_i,
  output mppt_spo_pkg::smp_t smp_o
);

  logic               in_vld_q;
  mppt_spo_pkg::in_t  in_q;
  logic               smp_vld_q;
  mppt_spo_pkg::smp_t smp_q, smp_d;
  logic               smp_rdy;
  logic               in_rdy;

  assign smp_rdy     = !smp_vld_q || smp_ready_i;
  assign in_rdy      = !in_vld_q || smp_rdy;
  assign in_ready_o  = in_rdy;
  assign smp_valid_o = smp_vld_q;
  assign smp_o       = smp_q;

  always_comb begin
    smp_d.volts = in_q.panel_voltage;
    smp_d.power = mppt_spo_pkg::PowerW'(in_q.panel_voltage * in_q.panel_current);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      smp_vld_q <= 1'b0;
    end else begin
      if (in_rdy) begin
        in_vld_q <= in_valid_i;
      end
      if (smp_rdy) begin
        smp_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (smp_rdy && in_vld_q) begin
      smp_q <= smp_d;
    end
  end

endmodule

### sv/mppt_spo_track.sv
// ----------------------------------------------------------------------------
// MPPT tracker state update
// Sweep and perturb-and-observe update of the duty; its state is the result.
// ----------------------------------------------------------------------------
module mppt_spo_track (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mppt_spo_pkg::cfg_t cfg_i,
  input  logic               smp_valid_i,
  output logic               smp_ready_o,
  input  mppt_spo_pkg::smp_t smp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mppt_spo_pkg::out_t out_data_o
);

  localparam int unsigned SumW = mppt_spo_pkg::DutyW + 2;

  logic                              out_vld_q;
  logic [mppt_spo_pkg::DutyW-1:0]    duty_q, duty_d;
  logic [mppt_spo_pkg::PowerW-1:0]   prev_q, prev_d;
  logic [mppt_spo_pkg::PowerW-1:0]   best_q, best_d;
  logic [mppt_spo_pkg::DutyW-1:0]    bduty_q, bduty_d;
  logic                              desc_q, desc_d;
  logic                              done_q, done_d;
  logic                              up_q, up_d;
  logic                              adv;
  logic [mppt_spo_pkg::DutyW:0]      inc;
  logic signed [SumW-1:0]            trk;
  logic signed [SumW-1:0]            dmax_s;
  logic signed [SumW-1:0]            dmin_s;
  logic signed [SumW-1:0]            step_s;

  assign smp_ready_o = !out_vld_q || out_ready_i;
  assign adv         = smp_ready_o && smp_valid_i;
  assign out_valid_o = out_vld_q;

  assign out_data_o.duty       = duty_q;
  assign out_data_o.tracking   = done_q;
  assign out_data_o.peak_duty  = bduty_q;
  assign out_data_o.peak_power = best_q;

  assign dmax_s = SumW'(signed'({1'b0, cfg_i.duty_max}));
  assign dmin_s = SumW'(signed'({1'b0, cfg_i.duty_min}));
  assign step_s = SumW'(signed'({1'b0, cfg_i.step_size}));

  always_comb begin
    duty_d  = duty_q;
    prev_d  = prev_q;
    best_d  = best_q;
    bduty_d = bduty_q;
    desc_d  = desc_q;
    done_d  = done_q;
    up_d    = up_q;
    inc     = {1'b0, duty_q} + 1'b1;
    trk     = '0;
    if (!done_q) begin
      if (smp_i.power > best_q) begin
        best_d  = smp_i.power;
        bduty_d = duty_q;
      end
      if (!desc_q) begin
        if (inc > {1'b0, cfg_i.duty_max}) begin
          inc    = {1'b0, cfg_i.duty_max};
          desc_d = 1'b1;
        end
        if (smp_i.volts <= cfg_i.min_sweep_voltage) begin
          inc    = {1'b0, bduty_d};
          desc_d = 1'b1;
        end
        duty_d = inc[mppt_spo_pkg::DutyW-1:0];
      end else if (duty_q > bduty_d) begin
        duty_d = duty_q - 1'b1;
      end else begin
        prev_d = smp_i.power;
        done_d = 1'b1;
        desc_d = 1'b0;
      end
    end else begin
      up_d = up_q ^ (smp_i.power < prev_q);
      if (up_d) begin
        trk = SumW'(signed'({1'b0, duty_q})) + step_s;
      end else begin
        trk = SumW'(signed'({1'b0, duty_q})) - step_s;
      end
      if (trk > dmax_s) begin
        trk = dmax_s;
      end
      if (trk < dmin_s) begin
        trk = dmin_s;
      end
      duty_d = trk[mppt_spo_pkg::DutyW-1:0];
      prev_d = smp_i.power;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      duty_q    <= mppt_spo_pkg::DutyMinReset;
      prev_q    <= '0;
      best_q    <= '0;
      bduty_q   <= '0;
      desc_q    <= 1'b0;
      done_q    <= 1'b0;
      up_q      <= 1'b1;
    end else begin
      if (smp_ready_o) begin
        out_vld_q <= smp_valid_i;
      end
      if (adv) begin
        duty_q  <= duty_d;
        prev_q  <= prev_d;
        best_q  <= best_d;
        bduty_q <= bduty_d;
        desc_q  <= desc_d;
        done_q  <= done_d;
        up_q    <= up_d;
      end
    end
  end

endmodule

### sv/mppt_sweep_perturb_observe.sv
// ----------------------------------------------------------------------------
// MPPT sweep and perturb-and-observe tracker
// Top level: configuration registers, power stage and tracker state update.
// ----------------------------------------------------------------------------
// Each word on the input channel is one panel voltage and current sample.
// Each sample yields exactly one output word with the new duty, the tracking
// flag and the peak duty and power found by the sweep.
// The sample is registered in the input register, then its voltage and power
// in the sample register, and then the state update in the tracker state
// registers, which form the output word.
// A new sample is taken in every cycle while the receiver does not stall; the throughput is then one word per cycle.
// The output word is held in the tracker state registers until it is taken.
// When the receiver stalls, the power stage and the input register still take
// up to two more samples before in_ready_o falls.
// Configuration words are taken in every cycle and apply to the next state
// update; they are to be written only while no sample is in flight.
// Reset loads all but the sample data registers: the duty starts at the reset
// value of duty_min and the block begins with an ascending sweep.
// ----------------------------------------------------------------------------
module mppt_sweep_perturb_observe (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mppt_spo_pkg::in_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mppt_spo_pkg::out_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  mppt_spo_pkg::cfg_idx_e         cfg_index_i,
  input  logic [mppt_spo_pkg::VoltW-1:0] cfg_data_i
);

  mppt_spo_pkg::cfg_t cfg;
  mppt_spo_pkg::smp_t smp;
  logic               smp_valid;
  logic               smp_ready;

  mppt_spo_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mppt_spo_power u_power (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .smp_valid_o (smp_valid),
    .smp_ready_i (smp_ready),
    .smp_o       (smp)
  );

  mppt_spo_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .smp_valid_i (smp_valid),
    .smp_ready_o (smp_ready),
    .smp_i       (smp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### sv/mppt_spo_checker.sv
// ----------------------------------------------------------------------------
// MPPT tracker port checker
// Checks the output handshake, the input stall and the tracking behavior seen on the ports.
// ----------------------------------------------------------------------------
module mppt_spo_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input mppt_spo_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled output word changed or was dropped.");

  a_full_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("Input stalled while the output side was free.");

  a_tracking_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_data_o.tracking) && $past(rst_ni) |-> out_data_o.tracking)
    else $error("Tracking flag cleared without reset.");

  a_peak_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_data_o.tracking) && $past(rst_ni) |->
      $stable(out_data_o.peak_power) && $stable(out_data_o.peak_duty))
    else $error("Peak changed while tracking.");

endmodule

bind mppt_sweep_perturb_observe mppt_spo_checker u_mppt_spo_checker (.*);

### tb/tb_mppt_sweep_perturb_observe.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the MPPT sweep and perturb-and-observe tracker
// Drives panel samples and register writes through valid/ready channels with
// random idling on both sides, predicts every output word from a cycle-free
// model of the sweep and tracking rules, and compares each word field by field.
// ----------------------------------------------------------------------------
module tb_mppt_sweep_perturb_observe;

  localparam int unsigned DutyW  = mppt_spo_pkg::DutyW;
  localparam int unsigned StepW  = mppt_spo_pkg::StepW;
  localparam int unsigned VoltW  = mppt_spo_pkg::VoltW;
  localparam int unsigned PowerW = mppt_spo_pkg::PowerW;

  localparam int WatchdogLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  mppt_spo_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mppt_spo_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  mppt_spo_pkg::cfg_idx_e cfg_index = mppt_spo_pkg::CFG_DUTY_MIN;
  logic [VoltW-1:0] cfg_data = '0;

  mppt_spo_pkg::in_t sample_q[$];
  mppt_spo_pkg::out_t duty_word_q[$];
  logic in_taken = 1'b0;
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 69;
  int n_errors = 0;
  int stall_cycles = 0;

  logic [DutyW-1:0] reg_duty_min = mppt_spo_pkg::DutyMinReset;
  logic [DutyW-1:0] reg_duty_max = mppt_spo_pkg::DutyMaxReset;
  logic [StepW-1:0] reg_step = mppt_spo_pkg::StepReset;
  logic [VoltW-1:0] reg_vmin = mppt_spo_pkg::MinVoltReset;

  logic [DutyW-1:0] trk_duty = mppt_spo_pkg::DutyMinReset;
  logic [PowerW-1:0] trk_prev_power = '0;
  logic [PowerW-1:0] trk_peak_power = '0;
  logic [DutyW-1:0] trk_peak_duty = '0;
  logic trk_falling = 1'b0;
  logic trk_locked = 1'b0;
  logic trk_rising = 1'b1;

  mppt_sweep_perturb_observe u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  function automatic mppt_spo_pkg::out_t predict_tracker_step(mppt_spo_pkg::in_t s);
    logic [PowerW-1:0] power;
    logic [DutyW:0] climb;
    int nxt;
    mppt_spo_pkg::out_t r;
    power = PowerW'(s.panel_voltage) * PowerW'(s.panel_current);
    if (!trk_locked) begin
      if (power > trk_peak_power) begin
        trk_peak_power = power;
        trk_peak_duty = trk_duty;
      end
      if (!trk_falling) begin
        climb = {1'b0, trk_duty} + 1'b1;
        if (climb > {1'b0, reg_duty_max}) begin
          climb = {1'b0, reg_duty_max};
          trk_falling = 1'b1;
        end
        if (s.panel_voltage <= reg_vmin) begin
          climb = {1'b0, trk_peak_duty};
          trk_falling = 1'b1;
        end
        trk_duty = climb[DutyW-1:0];
      end else if (trk_duty > trk_peak_duty) begin
        trk_duty = trk_duty - 1'b1;
      end else begin
        trk_prev_power = power;
        trk_locked = 1'b1;
        trk_falling = 1'b0;
      end
    end else begin
      if (power < trk_prev_power) trk_rising = !trk_rising;
      if (trk_rising) nxt = int'(trk_duty) + int'(reg_step);
      else nxt = int'(trk_duty) - int'(reg_step);
      if (nxt > int'(reg_duty_max)) nxt = int'(reg_duty_max);
      if (nxt < int'(reg_duty_min)) nxt = int'(reg_duty_min);
      trk_duty = nxt[DutyW-1:0];
      trk_prev_power = power;
    end
    r.duty = trk_duty;
    r.tracking = trk_locked;
    r.peak_duty = trk_peak_duty;
    r.peak_power = trk_peak_power;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    n_errors++;
  endtask

  task automatic compare_field(input string name, input logic [PowerW-1:0] got,
                               input logic [PowerW-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_taken) begin
        if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= sample_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    mppt_spo_pkg::out_t got;
    mppt_spo_pkg::out_t want;
    if (rst_ni) begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        got = out_data;
        if (duty_word_q.size() == 0) begin
          report_mismatch($sformatf("word with no sample waiting, duty %0d", got.duty));
        end else begin
          want = duty_word_q.pop_front();
          compare_field("duty", PowerW'(got.duty), PowerW'(want.duty));
          compare_field("tracking", PowerW'(got.tracking), PowerW'(want.tracking));
          compare_field("peak_duty", PowerW'(got.peak_duty), PowerW'(want.peak_duty));
          compare_field("peak_power", got.peak_power, want.peak_power);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mppt_spo_pkg::CFG_DUTY_MIN: reg_duty_min = cfg_data[DutyW-1:0];
          mppt_spo_pkg::CFG_DUTY_MAX: reg_duty_max = cfg_data[DutyW-1:0];
          mppt_spo_pkg::CFG_STEP_SIZE: reg_step = cfg_data[StepW-1:0];
          mppt_spo_pkg::CFG_MIN_SWEEP_VOLTAGE: reg_vmin = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) duty_word_q.push_back(predict_tracker_step(in_data));
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WatchdogLimit) begin
        $display("%0t ns: no handshake for %0d cycles", $realtime, WatchdogLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input mppt_spo_pkg::cfg_idx_e idx, input logic [VoltW-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic program_tracker(input int unsigned dmin, input int unsigned dmax,
                                 input int unsigned step, input int unsigned vmin);
    write_reg(mppt_spo_pkg::CFG_DUTY_MIN, VoltW'(dmin));
    write_reg(mppt_spo_pkg::CFG_DUTY_MAX, VoltW'(dmax));
    write_reg(mppt_spo_pkg::CFG_STEP_SIZE, VoltW'(step));
    write_reg(mppt_spo_pkg::CFG_MIN_SWEEP_VOLTAGE, VoltW'(vmin));
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (sample_q.size() != 0 || in_valid || duty_word_q.size() != 0);
  endtask

  task automatic push_sample(input int unsigned volts, input int unsigned amps);
    mppt_spo_pkg::in_t s;
    s.panel_voltage = VoltW'(volts);
    s.panel_current = VoltW'(amps);
    sample_q.push_back(s);
  endtask

  function automatic mppt_spo_pkg::in_t random_sample(mppt_spo_pkg::in_t last);
    mppt_spo_pkg::in_t s;
    case ($urandom_range(0, 9))
      0: s = last;
      1: begin
        s.panel_voltage = $urandom_range(0, 1) ? '1 : '0;
        s.panel_current = $urandom_range(0, 1) ? '1 : '0;
      end
      2: begin
        s = last;
        s.panel_current = s.panel_current ^ VoltW'($urandom_range(0, 255));
      end
      default: begin
        s.panel_voltage = VoltW'($urandom_range(0, 65535));
        s.panel_current = VoltW'($urandom_range(0, 65535));
      end
    endcase
    return s;
  endfunction

  initial begin
    int unsigned sweep_top;
    int unsigned vmin;
    int unsigned stop_at;
    int unsigned peak_at;
    int unsigned dmin;
    mppt_spo_pkg::in_t s;
    mppt_spo_pkg::in_t last;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The sweep runs once per reset, so it is kept short by a low ceiling.
    // A nonzero floor leaves the sweep free to settle below it.
    sweep_top = $urandom_range(12, 40);
    vmin = $urandom_range(1000, 20000);
    program_tracker($urandom_range(1, 6), sweep_top, $urandom_range(1, 1023), vmin);
    case ($urandom_range(0, 2))
      0: stop_at = 1000;
      1: stop_at = $urandom_range(1, sweep_top - 1);
      default: stop_at = sweep_top;
    endcase
    peak_at = $urandom_range(3, sweep_top - 1);
    last = '0;
    for (int i = 0; i < 2 * sweep_top + 3; i++) begin
      s.panel_voltage = VoltW'($urandom_range(vmin + 1, 65535));
      s.panel_current = VoltW'($urandom_range(0, 65535));
      if (i == 0) s.panel_current = '0;
      if (i == 2) s = last;
      if (i == peak_at) s = '1;
      if (i == stop_at) s.panel_voltage = VoltW'($urandom_range(0, vmin));
      sample_q.push_back(s);
      last = s;
    end
    wait_drained();

    program_tracker(0, 'h7FFF, 1023, 'hFFFF);
    push_sample('h0000, 'h0000);
    push_sample('hFFFF, 'hFFFF);
    push_sample('hFFFF, 'hFFFF);
    push_sample('hFFFF, 'hFFFE);
    push_sample('h0001, 'h0001);
    push_sample('h0000, 'hFFFF);
    push_sample('hFFFF, 'h0000);
    push_sample('hAAAA, 'h5555);
    push_sample('h5555, 'hAAAA);
    wait_drained();

    // Floor above ceiling: every tracking step lands on the floor.
    program_tracker('h7FFF, 0, $urandom_range(1, 1023), 0);
    for (int i = 0; i < 3; i++) push_sample($urandom_range(0, 65535), $urandom_range(0, 65535));
    wait_drained();

    program_tracker(0, 'h7FFF, 0, $urandom_range(0, 65535));
    for (int i = 0; i < 3; i++) push_sample($urandom_range(0, 65535), $urandom_range(0, 65535));
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      case ($urandom_range(0, 3))
        0: program_tracker(0, 'h7FFF, 1023, $urandom_range(0, 65535));
        1: program_tracker($urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 1023), $urandom_range(0, 65535));
        2: begin
          dmin = $urandom_range(0, 32000);
          program_tracker(dmin, dmin + $urandom_range(0, 700), $urandom_range(1, 1023),
                          $urandom_range(0, 65535));
        end
        default: program_tracker($urandom_range(0, 200), $urandom_range(32500, 32767),
                                 $urandom_range(0, 3), $urandom_range(0, 65535));
      endcase
      case (p / 3)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < 150; k++) begin
        s = random_sample(last);
        sample_q.push_back(s);
        last = s;
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (duty_word_q.size() != 0) begin
      report_mismatch($sformatf("%0d words never arrived", duty_word_q.size()));
    end
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
sv/mppt_spo_pkg.sv
sv/mppt_spo_cfg.sv
sv/mppt_spo_power.sv
sv/mppt_spo_track.sv
sv/mppt_sweep_perturb_observe.sv
sv/mppt_spo_checker.sv
tb/tb_mppt_sweep_perturb_observe.sv
